/* hdl/rlj_pkg.sv */
// ----------------------------------------------------------------------------
// rlj_pkg
// Types and constants shared by the redo log journal controller.
// ----------------------------------------------------------------------------
package rlj_pkg;

  localparam int unsigned BlkW    = 24;
  localparam int unsigned RegionW = 11;
  localparam int unsigned CountW  = 5;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned OpW     = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] REG_LOG_BASE   = 1'b0;
  localparam logic [CfgIdxW-1:0] REG_LOG_REGION = 1'b1;

  localparam logic [BlkW-1:0]    LOG_BASE_RST   = 24'd0;
  localparam logic [RegionW-1:0] LOG_REGION_RST = 11'd17;

  typedef enum logic [CmdW-1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_COMMIT = 2'd2
  } cmd_e;

  typedef enum logic [OpW-1:0] {
    OP_ACK     = 3'd0,
    OP_COPY    = 3'd1,
    OP_HEADER  = 3'd2,
    OP_ENTRY   = 3'd3,
    OP_INSTALL = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_FULL   = 2'd2,
    ST_NO_TXN = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK,
    S_SEARCH,
    S_COPY,
    S_HEADER,
    S_ENTRY,
    S_SKIP,
    S_INSTALL,
    S_CLEAR
  } state_e;

  // search token walking down the cell row
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [CountW-1:0] idx;
  } tok_t;

  // per-cycle command to all cells
  typedef struct packed {
    logic              wr;
    logic              rot;
    logic [CountW-1:0] idx;
    logic [BlkW-1:0]   data;
  } cell_ctl_t;

endpackage

/* hdl/rlj_if.sv */
// ----------------------------------------------------------------------------
// rlj_cmd_if / rlj_res_if
// Valid/ready channels for commands and result beats.
// ----------------------------------------------------------------------------
interface rlj_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [rlj_pkg::CmdW-1:0]  cmd;
  logic [rlj_pkg::BlkW-1:0]  block_number;

  modport source (output valid, cmd, block_number, input ready);
  modport sink   (input valid, cmd, block_number, output ready);
endinterface

interface rlj_res_if;
  logic                        valid;
  logic                        ready;
  logic [rlj_pkg::OpW-1:0]     op;
  logic [rlj_pkg::BlkW-1:0]    src_block;
  logic [rlj_pkg::BlkW-1:0]    dst_block;
  logic [rlj_pkg::CountW-1:0]  entry_count;
  logic [rlj_pkg::IndexW-1:0]  entry_index;
  logic [rlj_pkg::StatusW-1:0] status;
  logic                        last;

  modport source (output valid, op, src_block, dst_block, entry_count, entry_index,
                  status, last, input ready);
  modport sink   (input valid, op, src_block, dst_block, entry_count, entry_index,
                  status, last, output ready);
endinterface

/* hdl/redo_log_journal_controller.sv */
// ----------------------------------------------------------------------------
// redo_log_journal_controller
// Single-transaction redo log controller with block absorption.
// ----------------------------------------------------------------------------
// One command is handled at a time. Begin, rejected writes and empty commits
// give one beat, which is loaded into the output register from the ACK state;
// the next command can be taken after that. In a logged write the search
// token walks the row of LOG_DEPTH slot cells one cell per cycle before the
// copy beat is issued. A commit of n entries gives 2n + 2 beats, one per
// cycle while the output is not stalled; between the header and entry beats
// and the installs the slot ring turns back to its start. The next command is
// taken once the last beat of the current one sits in the output register.
module redo_log_journal_controller #(
  parameter int unsigned LOG_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rlj_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rlj_pkg::BlkW-1:0]    cfg_wdata_i,
  rlj_cmd_if.sink                     cmd_i,
  rlj_res_if.source                   res_o
);

  logic [rlj_pkg::BlkW-1:0]   blk_w [LOG_DEPTH];
  rlj_pkg::tok_t              tok_w [LOG_DEPTH+1];
  rlj_pkg::cell_ctl_t         ctl_w;
  logic [rlj_pkg::BlkW-1:0]   key_w;
  logic [rlj_pkg::CountW-1:0] total_w;

  rlj_ctrl #(
    .LogDepth (LOG_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd_i),
    .res_o       (res_o),
    .head_blk_i  (blk_w[0]),
    .tok_i       (tok_w[LOG_DEPTH]),
    .tok_o       (tok_w[0]),
    .key_o       (key_w),
    .total_o     (total_w),
    .ctl_o       (ctl_w)
  );

  for (genvar g = 0; g < LOG_DEPTH; g++) begin : g_cell
    rlj_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctl_i     (ctl_w),
      .total_i   (total_w),
      .key_i     (key_w),
      .nxt_blk_i (blk_w[(g + 1) % LOG_DEPTH]),
      .tok_i     (tok_w[g]),
      .blk_o     (blk_w[g]),
      .tok_o     (tok_w[g+1])
    );
  end

endmodule

/* hdl/rlj_cell.sv */
// ----------------------------------------------------------------------------
// rlj_cell
// One log slot: holds a home block, shifts in the ring, passes the search
// token on to the next slot.
// ----------------------------------------------------------------------------
module rlj_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rlj_pkg::cell_ctl_t         ctl_i,
  input  logic [rlj_pkg::CountW-1:0] total_i,
  input  logic [rlj_pkg::BlkW-1:0]   key_i,
  input  logic [rlj_pkg::BlkW-1:0]   nxt_blk_i,
  input  rlj_pkg::tok_t              tok_i,
  output logic [rlj_pkg::BlkW-1:0]   blk_o,
  output rlj_pkg::tok_t              tok_o
);

  localparam logic [rlj_pkg::CountW-1:0] MyIdx = rlj_pkg::CountW'(Idx);

  logic [rlj_pkg::BlkW-1:0] blk_q;
  rlj_pkg::tok_t            tok_q, tok_d;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && (ctl_i.idx == MyIdx)) begin
      blk_q <= ctl_i.data;
    end else if (ctl_i.rot) begin
      blk_q <= nxt_blk_i;
    end
  end

  always_comb begin
    tok_d = tok_i;
    if (tok_i.valid && !tok_i.hit && (MyIdx < total_i) && (blk_q == key_i)) begin
      tok_d.hit = 1'b1;
      tok_d.idx = MyIdx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign blk_o = blk_q;
  assign tok_o = tok_q;

endmodule

/* hdl/rlj_ctrl.sv */
// ----------------------------------------------------------------------------
// rlj_ctrl
// Command sequencer: transaction state, capacity checks, commit sequence,
// configuration registers and the result output register.
// ----------------------------------------------------------------------------
module rlj_ctrl #(
  parameter int unsigned LogDepth = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rlj_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [rlj_pkg::BlkW-1:0]    cfg_wdata_i,
  rlj_cmd_if.sink                     cmd_i,
  rlj_res_if.source                   res_o,
  input  logic [rlj_pkg::BlkW-1:0]    head_blk_i,
  input  rlj_pkg::tok_t               tok_i,
  output rlj_pkg::tok_t               tok_o,
  output logic [rlj_pkg::BlkW-1:0]    key_o,
  output logic [rlj_pkg::CountW-1:0]  total_o,
  output rlj_pkg::cell_ctl_t          ctl_o
);

  localparam int unsigned CW = $clog2(LogDepth + 1);
  localparam logic [CW-1:0] Depth   = CW'(LogDepth);
  localparam logic [CW-1:0] DepthM1 = CW'(LogDepth - 1);

  rlj_pkg::state_e state_q, state_d;

  logic                         txn_q, txn_d;
  logic [CW-1:0]                total_q, total_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic [rlj_pkg::BlkW-1:0]     key_q, key_d;
  logic [rlj_pkg::StatusW-1:0]  status_q, status_d;
  logic                         hit_q, hit_d;
  logic [CW-1:0]                hidx_q, hidx_d;
  logic                         launch_q, launch_d;
  logic [rlj_pkg::BlkW-1:0]     base_q;
  logic [rlj_pkg::RegionW-1:0]  region_q;

  logic                         ov_q, ov_d;
  logic                         load;
  logic [rlj_pkg::OpW-1:0]      op_q, op_d;
  logic [rlj_pkg::BlkW-1:0]     src_q, src_d;
  logic [rlj_pkg::BlkW-1:0]     dst_q, dst_d;
  logic [rlj_pkg::CountW-1:0]   ecnt_q, ecnt_d;
  logic [rlj_pkg::IndexW-1:0]   eidx_q, eidx_d;
  logic [rlj_pkg::StatusW-1:0]  st_q, st_d;
  logic                         last_q, last_d;

  logic                         emit;
  logic                         full;
  logic [CW-1:0]                sel_idx;
  logic [rlj_pkg::BlkW-1:0]     slot_blk;
  logic [rlj_pkg::BlkW-1:0]     inst_blk;

  assign emit     = !ov_q || res_o.ready;
  assign full     = (total_q >= Depth) ||
                    ((rlj_pkg::RegionW'(total_q) + rlj_pkg::RegionW'(1)) >= region_q);
  assign sel_idx  = hit_q ? hidx_q : total_q;
  assign slot_blk = base_q + rlj_pkg::BlkW'(sel_idx) + rlj_pkg::BlkW'(1);
  assign inst_blk = base_q + rlj_pkg::BlkW'(cnt_q) + rlj_pkg::BlkW'(1);

  assign cmd_i.ready = (state_q == rlj_pkg::S_IDLE);
  assign tok_o       = '{valid: launch_q, hit: 1'b0, idx: '0};
  assign key_o       = key_q;
  assign total_o     = rlj_pkg::CountW'(total_q);

  always_comb begin
    state_d  = state_q;
    txn_d    = txn_q;
    total_d  = total_q;
    cnt_d    = cnt_q;
    key_d    = key_q;
    status_d = status_q;
    hit_d    = hit_q;
    hidx_d   = hidx_q;
    launch_d = 1'b0;
    load     = 1'b0;
    op_d     = rlj_pkg::OP_ACK;
    src_d    = '0;
    dst_d    = '0;
    ecnt_d   = '0;
    eidx_d   = '0;
    st_d     = rlj_pkg::ST_OK;
    last_d   = 1'b0;
    ctl_o    = '0;

    unique case (state_q)
      rlj_pkg::S_IDLE: begin
        if (cmd_i.valid) begin
          key_d    = cmd_i.block_number;
          status_d = rlj_pkg::ST_OK;
          state_d  = rlj_pkg::S_ACK;
          case (cmd_i.cmd)
            rlj_pkg::CMD_BEGIN: begin
              if (txn_q) begin
                status_d = rlj_pkg::ST_BUSY;
              end
              txn_d = 1'b1;
            end
            rlj_pkg::CMD_WRITE: begin
              if (full) begin
                status_d = rlj_pkg::ST_FULL;
              end else if (!txn_q) begin
                status_d = rlj_pkg::ST_NO_TXN;
              end else begin
                launch_d = 1'b1;
                state_d  = rlj_pkg::S_SEARCH;
              end
            end
            rlj_pkg::CMD_COMMIT: begin
              if (total_q == '0) begin
                txn_d = 1'b0;
              end else begin
                state_d = rlj_pkg::S_HEADER;
              end
            end
            default: ;
          endcase
        end
      end
      rlj_pkg::S_ACK: begin
        if (emit) begin
          load    = 1'b1;
          st_d    = status_q;
          last_d  = 1'b1;
          state_d = rlj_pkg::S_IDLE;
        end
      end
      rlj_pkg::S_SEARCH: begin
        if (tok_i.valid) begin
          hit_d   = tok_i.hit;
          hidx_d  = CW'(tok_i.idx);
          state_d = rlj_pkg::S_COPY;
        end
      end
      rlj_pkg::S_COPY: begin
        if (emit) begin
          ctl_o.wr   = 1'b1;
          ctl_o.idx  = rlj_pkg::CountW'(sel_idx);
          ctl_o.data = key_q;
          load       = 1'b1;
          op_d       = rlj_pkg::OP_COPY;
          src_d      = key_q;
          dst_d      = slot_blk;
          eidx_d     = rlj_pkg::IndexW'(sel_idx);
          last_d     = 1'b1;
          if (!hit_q) begin
            total_d = total_q + CW'(1);
          end
          state_d = rlj_pkg::S_IDLE;
        end
      end
      rlj_pkg::S_HEADER: begin
        if (emit) begin
          load    = 1'b1;
          op_d    = rlj_pkg::OP_HEADER;
          dst_d   = base_q;
          ecnt_d  = rlj_pkg::CountW'(total_q);
          cnt_d   = '0;
          state_d = rlj_pkg::S_ENTRY;
        end
      end
      rlj_pkg::S_ENTRY: begin
        if (emit) begin
          load      = 1'b1;
          op_d      = rlj_pkg::OP_ENTRY;
          src_d     = head_blk_i;
          dst_d     = base_q;
          eidx_d    = rlj_pkg::IndexW'(cnt_q);
          ctl_o.rot = 1'b1;
          cnt_d     = cnt_q + CW'(1);
          if (cnt_q == total_q - CW'(1)) begin
            if (total_q == Depth) begin
              cnt_d   = '0;
              state_d = rlj_pkg::S_INSTALL;
            end else begin
              state_d = rlj_pkg::S_SKIP;
            end
          end
        end
      end
      rlj_pkg::S_SKIP: begin
        // finish the ring turn so slot 0 is back at the head
        ctl_o.rot = 1'b1;
        if (cnt_q == DepthM1) begin
          cnt_d   = '0;
          state_d = rlj_pkg::S_INSTALL;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      rlj_pkg::S_INSTALL: begin
        if (emit) begin
          load      = 1'b1;
          op_d      = rlj_pkg::OP_INSTALL;
          src_d     = inst_blk;
          dst_d     = head_blk_i;
          eidx_d    = rlj_pkg::IndexW'(cnt_q);
          ctl_o.rot = 1'b1;
          cnt_d     = cnt_q + CW'(1);
          if (cnt_q == total_q - CW'(1)) begin
            state_d = rlj_pkg::S_CLEAR;
          end
        end
      end
      rlj_pkg::S_CLEAR: begin
        if (emit) begin
          load    = 1'b1;
          op_d    = rlj_pkg::OP_HEADER;
          dst_d   = base_q;
          last_d  = 1'b1;
          total_d = '0;
          txn_d   = 1'b0;
          state_d = rlj_pkg::S_IDLE;
        end
      end
      default: state_d = rlj_pkg::S_IDLE;
    endcase

    if (load) begin
      ov_d = 1'b1;
    end else if (res_o.ready) begin
      ov_d = 1'b0;
    end else begin
      ov_d = ov_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rlj_pkg::S_IDLE;
      txn_q    <= 1'b0;
      total_q  <= '0;
      cnt_q    <= '0;
      launch_q <= 1'b0;
      ov_q     <= 1'b0;
      base_q   <= rlj_pkg::LOG_BASE_RST;
      region_q <= rlj_pkg::LOG_REGION_RST;
    end else begin
      state_q  <= state_d;
      txn_q    <= txn_d;
      total_q  <= total_d;
      cnt_q    <= cnt_d;
      launch_q <= launch_d;
      ov_q     <= ov_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          rlj_pkg::REG_LOG_BASE:   base_q   <= cfg_wdata_i;
          rlj_pkg::REG_LOG_REGION: region_q <= cfg_wdata_i[rlj_pkg::RegionW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    hidx_q   <= hidx_d;
    if (load) begin
      op_q   <= op_d;
      src_q  <= src_d;
      dst_q  <= dst_d;
      ecnt_q <= ecnt_d;
      eidx_q <= eidx_d;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign res_o.valid       = ov_q;
  assign res_o.op          = op_q;
  assign res_o.src_block   = src_q;
  assign res_o.dst_block   = dst_q;
  assign res_o.entry_count = ecnt_q;
  assign res_o.entry_index = eidx_q;
  assign res_o.status      = st_q;
  assign res_o.last        = last_q;

endmodule

/* tb/sv/tb_redo_log_journal_controller.sv */
// ----------------------------------------------------------------------------
// tb_redo_log_journal_controller
// Self-checking bench for the redo log journal controller. Commands are fed
// in bursts from a backlog. A predictor of the journal state works out the
// beats that each accepted command causes. A monitor checks each beat against
// the oldest one due. The log registers are changed between phases, while the
// block is idle.
// ----------------------------------------------------------------------------
module tb_redo_log_journal_controller;

  localparam int unsigned LOG_DEPTH = 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned LONG_HOLD = 400;
  localparam logic [rlj_pkg::CmdW-1:0] CMD_NOP = 2'd3;

  typedef struct {
    logic [rlj_pkg::CmdW-1:0] cmd;
    logic [rlj_pkg::BlkW-1:0] blk;
  } journal_cmd_t;

  typedef struct packed {
    logic [rlj_pkg::OpW-1:0]     op;
    logic [rlj_pkg::BlkW-1:0]    src;
    logic [rlj_pkg::BlkW-1:0]    dst;
    logic [rlj_pkg::CountW-1:0]  cnt;
    logic [rlj_pkg::IndexW-1:0]  idx;
    logic [rlj_pkg::StatusW-1:0] st;
    logic                        last;
  } journal_beat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rlj_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [rlj_pkg::BlkW-1:0] cfg_wdata_i = '0;

  rlj_cmd_if cmd_if ();
  rlj_res_if res_if ();

  redo_log_journal_controller #(
    .LOG_DEPTH(LOG_DEPTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd_if),
    .res_o      (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // journal state as the block should hold it
  logic [rlj_pkg::BlkW-1:0]    log_base = rlj_pkg::LOG_BASE_RST;
  logic [rlj_pkg::RegionW-1:0] log_region = rlj_pkg::LOG_REGION_RST;
  logic [rlj_pkg::BlkW-1:0]    logged_home [LOG_DEPTH];
  int unsigned                 used_slots = 0;
  bit                          txn_open = 1'b0;

  journal_cmd_t  cmd_backlog[$];
  journal_beat_t beats_due[$];

  bit          cmd_taken = 1'b0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned toggle_cnt = 0;
  journal_beat_t got_beat, want_beat;

  function automatic logic [rlj_pkg::BlkW-1:0] slot_blk(int unsigned i);
    return rlj_pkg::BlkW'(log_base + i + 1);
  endfunction

  task automatic due_beat(input logic [rlj_pkg::OpW-1:0] op,
                          input logic [rlj_pkg::BlkW-1:0] src,
                          input logic [rlj_pkg::BlkW-1:0] dst,
                          input logic [rlj_pkg::CountW-1:0] cnt,
                          input logic [rlj_pkg::IndexW-1:0] idx,
                          input logic [rlj_pkg::StatusW-1:0] st,
                          input logic last);
    journal_beat_t b;
    b.op = op;
    b.src = src;
    b.dst = dst;
    b.cnt = cnt;
    b.idx = idx;
    b.st = st;
    b.last = last;
    beats_due.push_back(b);
  endtask

  task automatic journal_predict(input logic [rlj_pkg::CmdW-1:0] cmd,
                                 input logic [rlj_pkg::BlkW-1:0] blk);
    int unsigned slot;
    int unsigned n;
    case (cmd)
      rlj_pkg::CMD_BEGIN: begin
        if (txn_open) begin
          due_beat(rlj_pkg::OP_ACK, '0, '0, '0, '0, rlj_pkg::ST_BUSY, 1'b1);
        end else begin
          txn_open = 1'b1;
          due_beat(rlj_pkg::OP_ACK, '0, '0, '0, '0, rlj_pkg::ST_OK, 1'b1);
        end
      end
      rlj_pkg::CMD_WRITE: begin
        if (used_slots >= LOG_DEPTH || used_slots + 1 >= log_region) begin
          due_beat(rlj_pkg::OP_ACK, '0, '0, '0, '0, rlj_pkg::ST_FULL, 1'b1);
        end else if (!txn_open) begin
          due_beat(rlj_pkg::OP_ACK, '0, '0, '0, '0, rlj_pkg::ST_NO_TXN, 1'b1);
        end else begin
          for (slot = 0; slot < used_slots; slot++) begin
            if (logged_home[slot] == blk) break;
          end
          logged_home[slot] = blk;
          if (slot == used_slots) used_slots++;
          due_beat(rlj_pkg::OP_COPY, blk, slot_blk(slot), '0, rlj_pkg::IndexW'(slot),
                   rlj_pkg::ST_OK, 1'b1);
        end
      end
      rlj_pkg::CMD_COMMIT: begin
        n = used_slots;
        if (n > 0) begin
          due_beat(rlj_pkg::OP_HEADER, '0, log_base, rlj_pkg::CountW'(n), '0,
                   rlj_pkg::ST_OK, 1'b0);
          for (slot = 0; slot < n; slot++) begin
            due_beat(rlj_pkg::OP_ENTRY, logged_home[slot], log_base, '0,
                     rlj_pkg::IndexW'(slot), rlj_pkg::ST_OK, 1'b0);
          end
          for (slot = 0; slot < n; slot++) begin
            due_beat(rlj_pkg::OP_INSTALL, slot_blk(slot), logged_home[slot], '0,
                     rlj_pkg::IndexW'(slot), rlj_pkg::ST_OK, 1'b0);
          end
          due_beat(rlj_pkg::OP_HEADER, '0, log_base, '0, '0, rlj_pkg::ST_OK, 1'b1);
        end else begin
          due_beat(rlj_pkg::OP_ACK, '0, '0, '0, '0, rlj_pkg::ST_OK, 1'b1);
        end
        used_slots = 0;
        txn_open = 1'b0;
      end
      default: begin
        due_beat(rlj_pkg::OP_ACK, '0, '0, '0, '0, rlj_pkg::ST_OK, 1'b1);
      end
    endcase
  endtask

  // sender: bursts of commands with gaps, valid held until the command is taken
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!cmd_if.valid || cmd_taken) begin
        cmd_taken = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          cmd_if.valid <= 1'b1;
          cmd_if.cmd <= cmd_backlog[0].cmd;
          cmd_if.block_number <= cmd_backlog[0].blk;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 5))
              0, 1: gap_left = 0;
              2:    gap_left = $urandom_range(10, 25);
              default: gap_left = $urandom_range(1, 8);
            endcase
          end else begin
            burst_left--;
          end
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern switches between modes, plus a long hold on request
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      toggle_cnt++;
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_if.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= ($urandom_range(0, 3) != 0);
          2: res_if.ready <= toggle_cnt[0];
          default: res_if.ready <= (toggle_cnt[1:0] == 2'd0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cmd_if.valid && cmd_if.ready) begin
        journal_predict(cmd_if.cmd, cmd_if.block_number);
        void'(cmd_backlog.pop_front());
        cmd_taken = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        got_beat.op = res_if.op;
        got_beat.src = res_if.src_block;
        got_beat.dst = res_if.dst_block;
        got_beat.cnt = res_if.entry_count;
        got_beat.idx = res_if.entry_index;
        got_beat.st = res_if.status;
        got_beat.last = res_if.last;
        if (beats_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected beat: op %0d src %h dst %h cnt %0d idx %0d st %0d last %0d",
                     got_beat.op, got_beat.src, got_beat.dst, got_beat.cnt, got_beat.idx,
                     got_beat.st, got_beat.last);
          end
        end else begin
          want_beat = beats_due.pop_front();
          if (got_beat.op !== want_beat.op || got_beat.src !== want_beat.src ||
              got_beat.dst !== want_beat.dst || got_beat.cnt !== want_beat.cnt ||
              got_beat.idx !== want_beat.idx || got_beat.st !== want_beat.st ||
              got_beat.last !== want_beat.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("beat mismatch: exp op %0d src %h dst %h cnt %0d idx %0d st %0d last %0d",
                       want_beat.op, want_beat.src, want_beat.dst, want_beat.cnt,
                       want_beat.idx, want_beat.st, want_beat.last);
              $display("               got op %0d src %h dst %h cnt %0d idx %0d st %0d last %0d",
                       got_beat.op, got_beat.src, got_beat.dst, got_beat.cnt,
                       got_beat.idx, got_beat.st, got_beat.last);
            end
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [rlj_pkg::CmdW-1:0] cmd,
                          input logic [rlj_pkg::BlkW-1:0] blk);
    journal_cmd_t c;
    c.cmd = cmd;
    c.blk = blk;
    cmd_backlog.push_back(c);
  endtask

  task automatic cfg_write(input logic [rlj_pkg::CfgIdxW-1:0] idx,
                           input logic [rlj_pkg::BlkW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    if (idx == rlj_pkg::REG_LOG_BASE) log_base = data;
    else log_region = data[rlj_pkg::RegionW-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_log_regs(input logic [rlj_pkg::BlkW-1:0] base,
                              input int unsigned region);
    cfg_write(rlj_pkg::REG_LOG_BASE, base);
    cfg_write(rlj_pkg::REG_LOG_REGION, rlj_pkg::BlkW'(region));
  endtask

  task automatic drain;
    while (cmd_backlog.size() != 0 || beats_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // mostly well-formed transactions, some stray commands in between
  task automatic fill_random(input int unsigned target);
    int unsigned pushed;
    int unsigned n;
    int unsigned k;
    logic [rlj_pkg::BlkW-1:0] hot [6];
    pushed = 0;
    foreach (hot[h]) hot[h] = rlj_pkg::BlkW'($urandom);
    while (pushed < target) begin
      if ($urandom_range(0, 4) == 0) begin
        push_cmd(rlj_pkg::CmdW'($urandom_range(0, 3)), rlj_pkg::BlkW'($urandom));
        pushed++;
      end else begin
        push_cmd(rlj_pkg::CMD_BEGIN, rlj_pkg::BlkW'($urandom));
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 20) : $urandom_range(0, 8);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(0, 9) < 4) begin
            push_cmd(rlj_pkg::CMD_WRITE, hot[$urandom_range(0, 5)]);
          end else begin
            push_cmd(rlj_pkg::CMD_WRITE, rlj_pkg::BlkW'($urandom));
          end
        end
        push_cmd(rlj_pkg::CMD_COMMIT, rlj_pkg::BlkW'($urandom));
        pushed += n + 2;
      end
    end
  endtask

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.cmd = rlj_pkg::CMD_BEGIN;
    cmd_if.block_number = '0;
    res_if.ready = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_log_regs(24'd0, 17);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000000);
    push_cmd(rlj_pkg::CMD_COMMIT, 24'h000000);
    push_cmd(CMD_NOP, 24'hFFFFFF);
    push_cmd(rlj_pkg::CMD_BEGIN, 24'h000000);
    push_cmd(rlj_pkg::CMD_BEGIN, 24'h000000);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000000);
    push_cmd(rlj_pkg::CMD_WRITE, 24'hFFFFFF);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000000);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h555555);
    push_cmd(rlj_pkg::CMD_WRITE, 24'hAAAAAA);
    push_cmd(rlj_pkg::CMD_COMMIT, 24'h000000);
    push_cmd(rlj_pkg::CMD_COMMIT, 24'h000000);
    drain();

    // tiny log region at the top of the block space: full early, slots wrap
    set_log_regs(24'hFFFFFF, 3);
    push_cmd(rlj_pkg::CMD_BEGIN, 24'h000000);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000001);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000002);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000001);
    push_cmd(rlj_pkg::CMD_WRITE, 24'h000007);
    push_cmd(rlj_pkg::CMD_COMMIT, 24'h000000);
    drain();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: set_log_regs(rlj_pkg::BlkW'($urandom), 17);
        1: set_log_regs(24'hFFFFFF, 1024);
        2: set_log_regs(rlj_pkg::BlkW'($urandom), 2);
        3: set_log_regs(rlj_pkg::BlkW'($urandom), $urandom_range(2, 1024));
        default: set_log_regs(24'd0, 9);
      endcase
      fill_random(80);
      if (ph == 1) hold_cycles = LONG_HOLD;
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && beats_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
